>>> sv/gsc_pkg.sv
// shared types and constants for the ramped gain scaler
// no dependencies; imported by the controller, datapath and top level

package gsc_pkg;

	localparam int GAIN_W    = 24;
	localparam int LEN_W     = 16;
	localparam int ACC_EXTRA = 24;
	localparam int ACC_W     = GAIN_W + ACC_EXTRA;
	localparam int STEP_W    = ACC_W + 1;
	localparam int CFG_W     = GAIN_W;
	localparam int ADDR_W    = 1;

	localparam logic [ADDR_W-1:0] REG_TARGET_GAIN  = 1'b0;
	localparam logic [ADDR_W-1:0] REG_RAMP_SAMPLES = 1'b1;

	localparam logic [LEN_W-1:0] RAMP_RESET = 16'd480;

	typedef enum logic [1:0] {
		DIR_HOLD = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} gsc_dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_RES
	} gsc_state_t;

	typedef struct packed {
		logic load_in;
		logic mul_in;
		logic clamp;
		logic check;
		logic div_wr;
		logic mul_q;
		logic finish;
	} gsc_cmd_t;

	typedef struct packed {
		logic near;
		logic div_done;
		logic out_free;
	} gsc_sts_t;

endpackage

>>> sv/gsc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// unsigned dividend and divisor; standalone, no package use

module gsc_div #(
	parameter int DW = 48,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CW = $clog2(DW);
	localparam logic [CW-1:0] LAST = CW'(DW - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   rem_sh;
	logic [VW:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!rem_sub[VW]) begin
				rem_q <= rem_sub[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> sv/gsc_dp.sv
// datapath: config registers, gain accumulator, step divide, multiply, round and saturate
// depends on gsc_pkg and gsc_div

module gsc_dp #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [gsc_pkg::ADDR_W-1:0]    cfg_addr,
	input  logic [gsc_pkg::CFG_W-1:0]     cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          frame_last,
	input  gsc_pkg::gsc_cmd_t             cmd,
	output gsc_pkg::gsc_sts_t             sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [SAMPLE_BITS-1:0]        sample_out,
	output logic                          clipped
);

	import gsc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int GF = GAIN_FRAC_BITS;
	localparam int PW = SB + GAIN_W + 1;

	localparam logic [GAIN_W-1:0] TARGET_RESET = GAIN_W'(64'd1 << GF);
	localparam logic [ACC_W-1:0]  UNITY_ACC    = {TARGET_RESET, {ACC_EXTRA{1'b0}}};
	localparam logic signed [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (GF - 1);
	localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [STEP_W-1:0] NEAR_HI = STEP_W'(64'd1 << ACC_EXTRA);
	localparam logic signed [STEP_W-1:0] NEAR_LO = -NEAR_HI;

	logic [GAIN_W-1:0]         target_q;
	logic [LEN_W-1:0]          ramp_q;
	logic [ACC_W-1:0]          acc_q;
	logic signed [STEP_W-1:0]  step_q;
	gsc_dir_t                  dir_q;
	logic                      frame_open_q;
	logic                      neg_q;
	logic signed [SB-1:0]      sample_q;
	logic                      flast_q;
	logic signed [PW-1:0]      prod_s1;
	logic                      out_valid_q;
	logic [SB-1:0]             out_sample_q;
	logic                      out_clip_q;

	logic [ACC_W-1:0]          t_acc;
	logic [LEN_W-1:0]          len;
	logic signed [STEP_W-1:0]  diff;
	logic [ACC_W-1:0]          mag;
	logic                      near;
	logic                      div_start;
	logic [ACC_W-1:0]          quo;
	logic                      div_done;
	logic                      snap;
	logic                      mul;
	logic [GAIN_W-1:0]         gain;
	logic signed [SB-1:0]      mul_a;
	logic signed [GAIN_W:0]    mul_b;
	logic signed [PW:0]        rsum;
	logic signed [PW:0]        rshift;
	logic [PW-GF-SB+1:0]       hi_bits;
	logic                      sat;
	logic [SB-1:0]             res;
	logic signed [STEP_W:0]    adv;
	logic [ACC_W-1:0]          adv_sat;

	assign t_acc = {target_q, {ACC_EXTRA{1'b0}}};
	assign len   = (ramp_q == '0) ? LEN_W'(1) : ramp_q;
	assign diff  = $signed({1'b0, t_acc}) - $signed({1'b0, acc_q});
	assign near  = (diff < NEAR_HI) && (diff > NEAR_LO);
	assign mag   = diff[STEP_W-1] ? ACC_W'(-diff) : diff[ACC_W-1:0];
	assign div_start = cmd.check && !near;

	gsc_div #(
		.DW(ACC_W),
		.VW(LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (len),
		.quotient (quo),
		.done     (div_done)
	);

	// snap to target at the first channel of a frame once crossed
	assign snap = !frame_open_q &&
		((dir_q == DIR_UP && acc_q >= t_acc) || (dir_q == DIR_DOWN && acc_q <= t_acc));
	assign mul   = cmd.mul_in || cmd.mul_q;
	assign gain  = snap ? target_q : acc_q[ACC_W-1:ACC_EXTRA];
	assign mul_a = cmd.mul_in ? sample_in : sample_q;
	assign mul_b = $signed({1'b0, gain});

	// round half up, then saturate
	assign rsum    = $signed({prod_s1[PW-1], prod_s1}) + HALF;
	assign rshift  = rsum >>> GF;
	assign hi_bits = rshift[PW-GF:SB-1];
	assign sat     = !((&hi_bits) || !(|hi_bits));
	assign res     = sat ? (rshift[PW] ? SMIN : SMAX) : rshift[SB-1:0];

	assign adv = $signed({2'b00, acc_q}) + $signed({step_q[STEP_W-1], step_q});
	always_comb begin
		if (adv[STEP_W]) begin
			adv_sat = '0;
		end else if (adv[ACC_W]) begin
			adv_sat = '1;
		end else begin
			adv_sat = adv[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= TARGET_RESET;
			ramp_q       <= RAMP_RESET;
			acc_q        <= UNITY_ACC;
			step_q       <= '0;
			dir_q        <= DIR_HOLD;
			frame_open_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_addr)
					REG_TARGET_GAIN:  target_q <= cfg_data;
					REG_RAMP_SAMPLES: ramp_q   <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clamp) begin
				frame_open_q <= 1'b0;
				if ((dir_q == DIR_UP && acc_q > t_acc) ||
					(dir_q == DIR_DOWN && acc_q < t_acc)) begin
					acc_q <= t_acc;
				end
			end
			if (cmd.check && near) begin
				acc_q  <= t_acc;
				step_q <= '0;
				dir_q  <= DIR_HOLD;
			end
			if (cmd.div_wr) begin
				step_q <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
				if (quo == '0) begin
					dir_q <= DIR_HOLD;
				end else begin
					dir_q <= neg_q ? DIR_DOWN : DIR_UP;
				end
			end
			if (mul && snap) begin
				acc_q <= t_acc;
			end
			if (cmd.finish) begin
				out_valid_q  <= 1'b1;
				frame_open_q <= !flast_q;
				if (flast_q) begin
					acc_q <= adv_sat;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= sample_in;
			flast_q  <= frame_last;
		end
		if (div_start) begin
			neg_q <= diff[STEP_W-1];
		end
		if (mul) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (cmd.finish) begin
			out_sample_q <= res;
			out_clip_q   <= sat;
		end
	end

	assign sts.near     = near;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign sample_out = out_sample_q;
	assign clipped    = out_clip_q;

endmodule

>>> sv/gsc_ctrl.sv
// controller state machine sequencing the gain datapath
// depends on gsc_pkg

module gsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              block_start,
	input  gsc_pkg::gsc_sts_t sts,
	output logic              in_ready,
	output gsc_pkg::gsc_cmd_t cmd
);

	import gsc_pkg::*;

	gsc_state_t state_q;
	gsc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = block_start ? ST_CLAMP : ST_RES;
				end
			end
			ST_CLAMP: state_d = ST_CHECK;
			ST_CHECK: state_d = sts.near ? ST_MUL : ST_DIV;
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_RES;
			ST_RES: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				cmd.mul_in  = in_valid && !block_start;
			end
			ST_CLAMP: cmd.clamp  = 1'b1;
			ST_CHECK: cmd.check  = 1'b1;
			ST_DIV:   cmd.div_wr = sts.div_done;
			ST_MUL:   cmd.mul_q  = 1'b1;
			ST_RES:   cmd.finish = sts.out_free;
			default: ;
		endcase
	end

endmodule

>>> sv/ramped_gain_scaler_core.sv
// ramped gain scaler top level: stream ports, config port, controller and datapath
// depends on gsc_pkg, gsc_ctrl, gsc_dp (which holds gsc_div)

// Scales interleaved signed samples by a gain that ramps linearly toward the
// target_gain register (unsigned Q4.20) over ramp_samples frames, with the
// product rounded and saturated and clipped set on saturation. Results leave
// through an output register, so the next sample is taken while a result
// waits. An ordinary sample is multiplied as it is taken; the result state
// rounds, saturates and, at a frame's last sample, advances the gain. A
// block_start sample passes clamp, check, the step divide (one quotient bit
// per cycle over the 48-bit gain accumulator), multiply and result; the
// divide is skipped when the gain lies within one gain LSB of the target.
// Output stalls hold the result state. Write configuration only while idle.

module ramped_gain_scaler_core #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gsc_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [gsc_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample_in
	input  logic                                s_tlast,  // frame_last
	input  logic                                s_tuser,  // block_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // sample_out
	output logic                                m_tuser   // clipped
);

	import gsc_pkg::*;

	localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

	gsc_cmd_t               cmd;
	gsc_sts_t               sts;
	logic [SAMPLE_BITS-1:0] sample_out;

	assign cfg_ready = 1'b1;

	gsc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.block_start (s_tuser),
		.sts         (sts),
		.in_ready    (s_tready),
		.cmd         (cmd)
	);

	gsc_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.sample_in  ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.frame_last (s_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.sample_out (sample_out),
		.clipped    (m_tuser)
	);

	assign m_tdata = TDW'(sample_out);

endmodule

>>> tb/sv/ramped_gain_scaler_core_test.sv
`timescale 1ns / 100ps
// self-checking testbench for ramped_gain_scaler_core: stream driver, result monitor and
// a gain ramp predictor; depends on gsc_pkg and the ramped_gain_scaler_core rtl

module ramped_gain_scaler_core_test;
	import gsc_pkg::*;

	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 20;
	localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8;

	localparam longint ACC_ONE    = longint'(1) << ACC_EXTRA;
	localparam longint ACC_MAX    = (longint'(1) << ACC_W) - 1;
	localparam longint ROUND_HALF = longint'(1) << (GAIN_FRAC_BITS - 1);
	localparam longint SMP_MAX    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SMP_MIN    = -SMP_MAX - 1;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          block_start;
		logic                          frame_last;
	} audio_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clipped;
	} scaled_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ADDR_W-1:0]  cfg_addr  = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [DATA_W-1:0]  s_tdata   = '0;  // sample_in
	logic               s_tlast   = 1'b0;  // frame_last
	logic               s_tuser   = 1'b0;  // block_start
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [DATA_W-1:0]  m_tdata;  // sample_out
	logic               m_tuser;  // clipped

	ramped_gain_scaler_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// gain ramp state as the block keeps it
	logic [GAIN_W-1:0]        target_q  = UNITY_GAIN;
	logic [LEN_W-1:0]         ramp_q    = RAMP_RESET;
	logic [ACC_W-1:0]         gain_q    = ACC_W'(1) << (GAIN_FRAC_BITS + ACC_EXTRA);
	logic signed [STEP_W-1:0] step_q    = '0;
	gsc_dir_t                 dir_q     = DIR_HOLD;
	bit                       in_frame  = 1'b0;

	audio_item_t pending_samples[$];
	scaled_t     scaled_expected[$];
	audio_item_t bus_item;
	scaled_t     got;
	scaled_t     want;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int mismatches     = 0;
	int samples_sent   = 0;
	int blocks_seen    = 0;
	int clips_seen     = 0;
	int reg_writes     = 0;

	function automatic scaled_t scale_sample(audio_item_t it);
		longint  tgt;
		longint  acc;
		longint  diff;
		longint  len;
		longint  st;
		longint  prod;
		longint  res;
		scaled_t r;
		tgt = longint'(target_q) << ACC_EXTRA;
		acc = longint'(gain_q);
		st  = longint'(step_q);
		if (it.block_start) begin
			blocks_seen++;
			len = (ramp_q == '0) ? longint'(1) : longint'(ramp_q);
			if (dir_q == DIR_UP && acc > tgt)
				acc = tgt;
			else if (dir_q == DIR_DOWN && acc < tgt)
				acc = tgt;
			diff = tgt - acc;
			if (diff < ACC_ONE && diff > -ACC_ONE) begin
				acc   = tgt;
				st    = 0;
				dir_q = DIR_HOLD;
			end else begin
				st    = diff / len;
				dir_q = (st > 0) ? DIR_UP : ((st < 0) ? DIR_DOWN : DIR_HOLD);
			end
			in_frame = 1'b0;
		end
		if (!in_frame) begin
			if ((dir_q == DIR_UP && acc >= tgt) || (dir_q == DIR_DOWN && acc <= tgt))
				acc = tgt;
		end
		prod = longint'(it.sample) * (acc >>> ACC_EXTRA) + ROUND_HALF;
		res  = prod >>> GAIN_FRAC_BITS;
		r.clipped = 1'b0;
		if (res > SMP_MAX) begin
			res = SMP_MAX;
			r.clipped = 1'b1;
		end else if (res < SMP_MIN) begin
			res = SMP_MIN;
			r.clipped = 1'b1;
		end
		r.sample = res[SAMPLE_BITS-1:0];
		if (it.frame_last) begin
			acc = acc + st;
			if (acc < 0)
				acc = 0;
			else if (acc > ACC_MAX)
				acc = ACC_MAX;
			in_frame = 1'b0;
		end else begin
			in_frame = 1'b1;
		end
		gain_q = acc[ACC_W-1:0];
		step_q = st[STEP_W-1:0];
		return r;
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				scaled_expected.push_back(scale_sample(bus_item));
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					bus_item = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= DATA_W'(bus_item.sample);
					s_tuser  <= bus_item.block_start;
					s_tlast  <= bus_item.frame_last;
					samples_sent++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.sample  = m_tdata[SAMPLE_BITS-1:0];
				got.clipped = m_tuser;
				if (got.clipped)
					clips_seen++;
				if (scaled_expected.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: expected none, got %0d clipped %0b",
						$time, got.sample, got.clipped);
				end else begin
					want = scaled_expected.pop_front();
					if (got.sample !== want.sample || got.clipped !== want.clipped) begin
						mismatches++;
						$display("%0t: result mismatch: expected %0d clipped %0b, got %0d clipped %0b",
							$time, want.sample, want.clipped, got.sample, got.clipped);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (addr == REG_TARGET_GAIN)
			target_q = data;
		else
			ramp_q = data[LEN_W-1:0];
		reg_writes++;
	endtask

	task automatic queue_sample(input longint smp, input bit bs, input bit fl);
		audio_item_t it;
		it.sample      = smp[SAMPLE_BITS-1:0];
		it.block_start = bs;
		it.frame_last  = fl;
		pending_samples.push_back(it);
	endtask

	// waits for every queued sample to come back scaled
	task automatic drain();
		do @(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || scaled_expected.size() != 0);
	endtask

	function automatic longint rand_sample();
		longint v;
		case ($urandom_range(9))
			0: v = SMP_MAX;
			1: v = SMP_MIN;
			2, 3, 4: v = longint'($signed(SAMPLE_BITS'($urandom())));
			default: begin
				v = longint'($urandom_range(0, 1 << 19));
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// well-formed blocks of interleaved frames, with some broken flags mixed in
	task automatic queue_blocks(input int count);
		int n;
		int chans;
		int frames;
		bit bs;
		bit fl;
		n = 0;
		while (n < count) begin
			chans  = $urandom_range(1, 4);
			frames = $urandom_range(1, 10);
			for (int f = 0; f < frames; f++) begin
				for (int c = 0; c < chans; c++) begin
					bs = (f == 0 && c == 0);
					fl = (c == chans - 1);
					if ($urandom_range(99) < 8) begin
						bs = 1'($urandom_range(1));
						fl = 1'($urandom_range(1));
					end
					queue_sample(rand_sample(), bs, fl);
					n++;
				end
			end
		end
	endtask

	initial begin
		logic [GAIN_W-1:0] tgt;
		logic [LEN_W-1:0]  len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, unity gain passes samples through unchanged
		queue_sample(SMP_MAX, 1, 0);
		queue_sample(SMP_MIN, 0, 1);
		queue_sample(0, 0, 0);
		queue_sample(-1, 0, 1);
		queue_sample(1, 0, 1);
		drain();

		// full-scale target with zero ramp length, clipping and block start mid-frame
		write_reg(REG_TARGET_GAIN, 24'hFFFFFF);
		write_reg(REG_RAMP_SAMPLES, '0);
		@(negedge clk);
		queue_sample(SMP_MAX, 1, 1);
		queue_sample(SMP_MAX, 0, 1);
		queue_sample(SMP_MIN, 0, 0);
		queue_sample(12345, 1, 0);
		queue_sample(-4096, 0, 1);
		drain();

		// ramp down to zero gain
		write_reg(REG_TARGET_GAIN, '0);
		write_reg(REG_RAMP_SAMPLES, CFG_W'(16'd3));
		@(negedge clk);
		repeat (4) queue_sample(64'sh400000, 0, 1);
		queue_sample(SMP_MIN, 0, 1);
		pending_samples[0].block_start = 1'b1;
		drain();

		// ramp that stops just short of the target, then snaps at the block start
		write_reg(REG_TARGET_GAIN, 24'd1000);
		@(negedge clk);
		queue_sample(SMP_MAX, 1, 1);
		queue_sample(SMP_MAX, 0, 1);
		queue_sample(SMP_MAX, 0, 1);
		queue_sample(SMP_MAX, 1, 1);
		drain();

		for (int p = 0; p < 8; p++) begin
			repeat (8) @(negedge clk);
			case (p)
				0: begin tgt = 24'hFFFFFF; len = 16'd1; end
				1: begin tgt = '0; len = 16'hFFFF; end
				2: begin tgt = UNITY_GAIN; len = LEN_W'($urandom_range(1, 6)); end
				3: begin tgt = GAIN_W'($urandom()); len = ramp_q; end
				4: begin
					tgt = GAIN_W'($urandom_range(0, 1 << 21));
					len = LEN_W'($urandom_range(1, 6));
				end
				5: begin tgt = 24'hFFFFFF; len = LEN_W'($urandom_range(2, 16)); end
				6: begin tgt = GAIN_W'($urandom()); len = LEN_W'($urandom_range(1, 300)); end
				default: begin
					tgt = UNITY_GAIN + GAIN_W'($urandom_range(0, 3));
					len = LEN_W'($urandom_range(1, 8));
				end
			endcase
			write_reg(REG_TARGET_GAIN, tgt);
			if (p != 3)
				write_reg(REG_RAMP_SAMPLES, CFG_W'(len));
			@(negedge clk);
			case (p % 4)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 81; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 81; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			queue_blocks(30);
			// sender holds off until everything has come back
			drain();
			queue_blocks(30);
			drain();
		end

		repeat (60) @(negedge clk);
		$display("sent %0d samples in %0d blocks over %0d register writes, %0d results saturated",
			samples_sent, blocks_seen, reg_writes, clips_seen);
		if (mismatches == 0 && scaled_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, scaled_expected.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", scaled_expected.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
sv/gsc_pkg.sv
sv/gsc_div.sv
sv/gsc_dp.sv
sv/gsc_ctrl.sv
sv/ramped_gain_scaler_core.sv
tb/sv/ramped_gain_scaler_core_test.sv
